// ===== rtl/sdat_pkg.sv =====
// Shared constants, types and the stiffness table for the aim tracker.
`default_nettype none

package sdat_pkg;

   localparam int ANGLE_W            = 15;
   localparam int DT_W               = 16;
   localparam int LEVEL_W            = 3;
   localparam int K_W                = 11;
   localparam int ACC_W              = 19;
   localparam int VELOCITY_BITS_DEF  = 24;

   localparam int FULL_TURN   = 23040;
   localparam int HALF_TURN   = 11520;
   localparam int TURN_HI     = FULL_TURN / 512;
   localparam int SNAP_TOL    = 32;
   localparam int AIM_TOL     = 192;
   localparam int ACCEL_LIMIT = 192000;

   localparam logic [LEVEL_W-1:0] LEVEL_INSTANT = 3'd5;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_MIN_LEVEL = 2'd0,
      REG_MAX_LEVEL = 2'd1,
      REG_EASY      = 2'd2,
      REG_NONE      = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic start;
      logic instant;
   } lane_ctl_type;

   typedef struct packed {
      logic done;
      logic near;
   } lane_sts_type;

   function automatic logic [K_W-2:0] stiffness(input logic [LEVEL_W-1:0] level);
      logic [K_W-2:0] k;
      case (level)
         3'd0:    k = 10'd90;
         3'd1:    k = 10'd110;
         3'd2:    k = 10'd150;
         3'd3:    k = 10'd180;
         3'd4:    k = 10'd200;
         3'd5:    k = 10'd999;
         default: k = 10'd150;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/spring_damper_aim_tracker_core.sv =====
// Top level: register port, speed level, yaw and pitch lanes, result merge.
// One item in flight: req_stall holds new beats off until the result of the last
// one is loaded into the output register. Each lane is a nine-stage multiply chain
// (error, spring/damper, velocity, position, modulo wrap).
// A finished result waits in the output register while the next beat is taken.
// Reset (synchronous) zeroes both velocities and loads levels 2/4, easy off.
`default_nettype none

module spring_damper_aim_tracker_core
   import sdat_pkg::*;
#(
   parameter int VELOCITY_BITS = VELOCITY_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [ANGLE_W-1:0]      req_target_yaw,
   input  wire logic [ANGLE_W-1:0]      req_target_pitch,
   input  wire logic [ANGLE_W-1:0]      req_view_yaw,
   input  wire logic [ANGLE_W-1:0]      req_view_pitch,
   input  wire logic [DT_W-1:0]         req_time_step,
   input  wire logic                    req_is_moving,
   input  wire logic                    req_alerted_or_fighting,
   input  wire logic                    req_under_attack,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [ANGLE_W-1:0]           rsp_new_yaw,
   output logic [ANGLE_W-1:0]           rsp_new_pitch,
   output logic                         rsp_in_aim_range,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]        csr_prdata,
   output logic                         csr_pready
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUSY,
      ST_HOLD
   } state_type;

   state_type state_ff, state_in;

   logic [LEVEL_W-1:0] min_lvl_ff, min_lvl_in, max_lvl_ff, max_lvl_in;
   logic               easy_ff, easy_in;

   logic [ANGLE_W-1:0] ty_ff, ty_in, tp_ff, tp_in, vy_ff, vy_in, vp_ff, vp_in;
   logic [DT_W-1:0]    dt_ff, dt_in;
   logic [K_W-2:0]     k_ff, k_in;
   logic               instant_ff, instant_in;
   logic               start_ff, start_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [ANGLE_W-1:0] rsp_yaw_ff, rsp_yaw_in, rsp_pitch_ff, rsp_pitch_in;
   logic               rsp_range_ff, rsp_range_in;

   logic               accept, out_free, load_out, csr_wr;
   logic [3:0]         lvl_sum;
   logic [LEVEL_W-1:0] lvl;
   reg_index_type      csr_idx;

   lane_ctl_type       ctl;
   lane_sts_type       sts_yaw, sts_pitch;
   logic [ANGLE_W-1:0] ang_yaw, ang_pitch;

   assign csr_idx    = reg_index_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_idx)
         REG_MIN_LEVEL: csr_prdata = CSR_DATA_W'(min_lvl_ff);
         REG_MAX_LEVEL: csr_prdata = CSR_DATA_W'(max_lvl_ff);
         REG_EASY:      csr_prdata = CSR_DATA_W'(easy_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      lvl_sum = 4'(min_lvl_ff) + 4'(req_is_moving);
      if (!easy_ff) begin
         lvl_sum = lvl_sum + 4'(req_alerted_or_fighting) + 4'(req_under_attack);
      end
      if (min_lvl_ff == LEVEL_INSTANT) begin
         lvl = LEVEL_INSTANT;
      end else if (lvl_sum > 4'(max_lvl_ff)) begin
         lvl = max_lvl_ff;
      end else begin
         lvl = lvl_sum[LEVEL_W-1:0];
      end
   end

   always_comb begin
      min_lvl_in = min_lvl_ff;
      max_lvl_in = max_lvl_ff;
      easy_in    = easy_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_MIN_LEVEL: min_lvl_in = csr_pwdata[LEVEL_W-1:0];
            REG_MAX_LEVEL: max_lvl_in = csr_pwdata[LEVEL_W-1:0];
            REG_EASY:      easy_in    = csr_pwdata[0];
            default:       ;
         endcase
      end

      ty_in      = ty_ff;
      tp_in      = tp_ff;
      vy_in      = vy_ff;
      vp_in      = vp_ff;
      dt_in      = dt_ff;
      k_in       = k_ff;
      instant_in = instant_ff;
      if (accept) begin
         ty_in      = req_target_yaw;
         tp_in      = req_target_pitch;
         vy_in      = req_view_yaw;
         vp_in      = req_view_pitch;
         dt_in      = req_time_step;
         k_in       = stiffness(lvl);
         instant_in = (lvl == LEVEL_INSTANT);
      end
      start_in = accept;

      state_in = state_ff;
      load_out = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_BUSY;
         end
         ST_BUSY: begin
            if (sts_yaw.done) begin
               if (out_free) begin
                  load_out = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_yaw_in   = rsp_yaw_ff;
      rsp_pitch_in = rsp_pitch_ff;
      rsp_range_in = rsp_range_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_yaw_in   = ang_yaw;
         rsp_pitch_in = ang_pitch;
         rsp_range_in = sts_yaw.near && sts_pitch.near;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_lvl_ff   <= 3'd2;
         max_lvl_ff   <= 3'd4;
         easy_ff      <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_lvl_ff   <= min_lvl_in;
         max_lvl_ff   <= max_lvl_in;
         easy_ff      <= easy_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ty_ff        <= ty_in;
      tp_ff        <= tp_in;
      vy_ff        <= vy_in;
      vp_ff        <= vp_in;
      dt_ff        <= dt_in;
      k_ff         <= k_in;
      instant_ff   <= instant_in;
      rsp_yaw_ff   <= rsp_yaw_in;
      rsp_pitch_ff <= rsp_pitch_in;
      rsp_range_ff <= rsp_range_in;
   end

   assign ctl.start   = start_ff;
   assign ctl.instant = instant_ff;

   sdat_lane #(
      .VB (VELOCITY_BITS)
   ) u_lane_yaw (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .k      ({1'b0, k_ff}),
      .dt     (dt_ff),
      .target (ty_ff),
      .view   (vy_ff),
      .sts    (sts_yaw),
      .angle  (ang_yaw)
   );

   sdat_lane #(
      .VB (VELOCITY_BITS)
   ) u_lane_pitch (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .k      ({k_ff, 1'b0}),
      .dt     (dt_ff),
      .target (tp_ff),
      .view   (vp_ff),
      .sts    (sts_pitch),
      .angle  (ang_pitch)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_new_yaw      = rsp_yaw_ff;
   assign rsp_new_pitch    = rsp_pitch_ff;
   assign rsp_in_aim_range = rsp_range_ff;

endmodule

`default_nettype wire

// ===== rtl/sdat_lane.sv =====
// One axis lane: error, spring/damper step, velocity state and angle wrap.
`default_nettype none

module sdat_lane
   import sdat_pkg::*;
#(
   parameter int VB = VELOCITY_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lane_ctl_type         ctl,
   input  wire logic [K_W-1:0]       k,
   input  wire logic [DT_W-1:0]      dt,
   input  wire logic [ANGLE_W-1:0]   target,
   input  wire logic [ANGLE_W-1:0]   view,
   output lane_sts_type              sts,
   output logic [ANGLE_W-1:0]        angle
);

   localparam int NS  = 9;
   localparam int KEW = 28;
   localparam int DVW = VB + 5;
   localparam int DW  = ((DVW > KEW) ? DVW : KEW) + 1;
   localparam int PAW = DT_W + 1 + ACC_W;
   localparam int SW  = ((VB > 20) ? VB : 20) + 1;
   localparam int PVW = DT_W + 1 + VB;
   localparam int UW  = VB + 3;
   localparam int HB  = UW - 9;
   localparam int MB  = HB - 5;
   localparam longint unsigned OFS = ((64'd1 << (VB + 1)) / FULL_TURN + 1) * FULL_TURN;
   localparam logic [UW-1:0] OFS_U = UW'(OFS);
   localparam logic [MB-1:0] RECIP = MB'((64'd1 << HB) / TURN_HI);
   localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
   localparam logic signed [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};

   logic [NS-1:0] stg_ff, stg_in;

   logic [ANGLE_W-1:0]     tw_ff, tw_in, vw_ff, vw_in;
   logic signed [15:0]     err_ff, err_in, d_raw;
   logic                   snap_ff, snap_in, near_ff, near_in;
   logic signed [KEW-1:0]  ke_ff, ke_in;
   logic signed [DVW-1:0]  dv_ff, dv_in, vx;
   logic signed [DW-1:0]   diff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [PAW-1:0]  pa_ff, pa_in, pa_r;
   logic signed [19:0]     rpa;
   logic signed [SW-1:0]   vs;
   logic signed [VB-1:0]   vel_ff, vel_in;
   logic signed [PVW-1:0]  pv_ff, pv_in, pv_r;
   logic signed [VB:0]     rq;
   logic signed [UW-1:0]   rq_x;
   logic [UW-1:0]          u_ff, u_in;
   logic [HB+MB-1:0]       pm_ff, pm_in;
   logic [HB-1:0]          h, rem0, rem1;
   logic [MB-1:0]          qe;
   logic [ANGLE_W-1:0]     angle_ff, angle_in;
   logic                   near_o_ff, near_o_in;

   always_comb begin
      stg_in = {stg_ff[NS-2:0], ctl.start};

      tw_in = (target >= ANGLE_W'(FULL_TURN)) ? target - ANGLE_W'(FULL_TURN) : target;
      vw_in = (view >= ANGLE_W'(FULL_TURN)) ? view - ANGLE_W'(FULL_TURN) : view;
      d_raw = $signed({1'b0, tw_in}) - $signed({1'b0, vw_in});
      if (d_raw > 16'sd11520) begin
         err_in = d_raw - 16'sd23040;
      end else if (d_raw <= -16'sd11520) begin
         err_in = d_raw + 16'sd23040;
      end else begin
         err_in = d_raw;
      end
      snap_in = ctl.instant || (err_in > -16'(SNAP_TOL) && err_in < 16'(SNAP_TOL));
      near_in = (err_in > -16'(AIM_TOL)) && (err_in < 16'(AIM_TOL));

      ke_in = $signed({1'b0, k}) * err_ff;
      vx    = DVW'(vel_ff);
      dv_in = (vx <<< 4) + (vx <<< 3) + vx;

      diff = DW'(ke_ff) - DW'(dv_ff);
      if (diff > DW'(ACCEL_LIMIT)) begin
         acc_in = ACC_W'(ACCEL_LIMIT);
      end else if (diff < -DW'(ACCEL_LIMIT)) begin
         acc_in = -ACC_W'(ACCEL_LIMIT);
      end else begin
         acc_in = ACC_W'(diff);
      end

      pa_in = $signed({1'b0, dt}) * acc_ff;
      pa_r  = pa_ff + PAW'(32768);
      rpa   = $signed(pa_r[PAW-1:16]);
      vs    = SW'(vel_ff) + SW'(rpa);
      if (!stg_ff[3]) begin
         vel_in = vel_ff;
      end else if (snap_ff) begin
         vel_in = '0;
      end else if (vs > SW'(VMAX)) begin
         vel_in = VMAX;
      end else if (vs < SW'(VMIN)) begin
         vel_in = VMIN;
      end else begin
         vel_in = VB'(vs);
      end

      pv_in = $signed({1'b0, dt}) * vel_ff;
      pv_r  = pv_ff + PVW'(32768);
      rq    = $signed(pv_r[PVW-1:16]);
      rq_x  = UW'(rq);
      u_in  = rq_x + UW'(vw_ff) + OFS_U;

      h     = u_ff[UW-1:9];
      pm_in = (HB+MB)'(h) * (HB+MB)'(RECIP);
      qe    = pm_ff[HB+MB-1:HB];
      rem0  = h - HB'(qe) * HB'(TURN_HI);
      rem1  = (rem0 >= HB'(TURN_HI)) ? rem0 - HB'(TURN_HI) : rem0;

      angle_in  = angle_ff;
      near_o_in = near_o_ff;
      if (stg_ff[NS-2]) begin
         angle_in  = snap_ff ? tw_ff : {rem1[5:0], u_ff[8:0]};
         near_o_in = near_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_ff <= '0;
         vel_ff <= '0;
      end else begin
         stg_ff <= stg_in;
         vel_ff <= vel_in;
      end
      tw_ff     <= tw_in;
      vw_ff     <= vw_in;
      err_ff    <= err_in;
      snap_ff   <= snap_in;
      near_ff   <= near_in;
      ke_ff     <= ke_in;
      dv_ff     <= dv_in;
      acc_ff    <= acc_in;
      pa_ff     <= pa_in;
      pv_ff     <= pv_in;
      u_ff      <= u_in;
      pm_ff     <= pm_in;
      angle_ff  <= angle_in;
      near_o_ff <= near_o_in;
   end

   assign sts.done = stg_ff[NS-1];
   assign sts.near = near_o_ff;
   assign angle    = angle_ff;

endmodule

`default_nettype wire

// ===== sim/spring_damper_aim_tracker_core_tb.sv =====
// Self-checking testbench for the aim tracker core: fixed-point tracker predictor and scoreboard.

typedef bit [sdat_pkg::ANGLE_W-1:0] angle_type;
typedef bit [sdat_pkg::DT_W-1:0]    step_type;

typedef struct packed {
   angle_type target_yaw;
   angle_type target_pitch;
   angle_type view_yaw;
   angle_type view_pitch;
   step_type  time_step;
   bit        moving;
   bit        alerted;
   bit        attacked;
} aim_item_type;

typedef struct packed {
   angle_type yaw;
   angle_type pitch;
   bit        in_range;
} aim_result_type;

class aim_scoreboard;
   int unsigned    min_level;
   int unsigned    max_level;
   bit             easy_mode;
   longint         yaw_vel;
   longint         pitch_vel;
   aim_result_type pending_q[$];
   aim_result_type last_pred;
   int             errors;

   function new();
      min_level = 2;
      max_level = 4;
      easy_mode = 1'b0;
      yaw_vel   = 0;
      pitch_vel = 0;
      errors    = 0;
      last_pred = '0;
   endfunction

   function void write_reg(sdat_pkg::reg_index_type idx, int unsigned value);
      case (idx)
         sdat_pkg::REG_MIN_LEVEL: min_level = value & 7;
         sdat_pkg::REG_MAX_LEVEL: max_level = value & 7;
         sdat_pkg::REG_EASY:      easy_mode = value[0];
         default: ;
      endcase
   endfunction

   function longint wrap_turn(longint a);
      longint r;
      r = a % sdat_pkg::FULL_TURN;
      if (r < 0) r += sdat_pkg::FULL_TURN;
      return r;
   endfunction

   // floor((x + 2^15) / 2^16)
   function longint round_q16(longint x);
      return (x + 64'sd32768) >>> 16;
   endfunction

   function longint sat_vel(longint v);
      longint hi;
      hi = (longint'(1) <<< (sdat_pkg::VELOCITY_BITS_DEF - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   function longint spring_of(int unsigned level);
      case (level)
         0:       return 90;
         1:       return 110;
         2:       return 150;
         3:       return 180;
         4:       return 200;
         5:       return 999;
         default: return 150;
      endcase
   endfunction

   function longint axis_error(longint target, longint view);
      longint d;
      d = wrap_turn(target - view);
      if (d > sdat_pkg::HALF_TURN) d -= sdat_pkg::FULL_TURN;
      return d;
   endfunction

   function longint advance_axis(longint target, longint view, longint err, longint k,
                                 bit instant, longint dt, inout longint vel);
      longint acc;
      if (instant || (err < sdat_pkg::SNAP_TOL && err > -sdat_pkg::SNAP_TOL)) begin
         vel = 0;
         return target;
      end
      acc = k * err - 25 * vel;
      if (acc > sdat_pkg::ACCEL_LIMIT) acc = sdat_pkg::ACCEL_LIMIT;
      else if (acc < -sdat_pkg::ACCEL_LIMIT) acc = -sdat_pkg::ACCEL_LIMIT;
      vel = sat_vel(vel + round_q16(dt * acc));
      return wrap_turn(view + round_q16(dt * vel));
   endfunction

   function void note_input(aim_item_type it);
      int unsigned    level;
      bit             instant;
      longint         k, ty, tp, vy, vp, dt, ey, ep;
      aim_result_type r;
      ty = wrap_turn(longint'(it.target_yaw));
      tp = wrap_turn(longint'(it.target_pitch));
      vy = wrap_turn(longint'(it.view_yaw));
      vp = wrap_turn(longint'(it.view_pitch));
      dt = longint'(it.time_step);
      level = min_level;
      if (min_level != sdat_pkg::LEVEL_INSTANT) begin
         level += it.moving;
         if (!easy_mode) level += it.alerted + it.attacked;
         if (level > max_level) level = max_level;
      end
      instant = (level == sdat_pkg::LEVEL_INSTANT);
      k = spring_of(level & 7);
      ey = axis_error(ty, vy);
      ep = axis_error(tp, vp);
      r.yaw   = angle_type'(advance_axis(ty, vy, ey, k, instant, dt, yaw_vel));
      r.pitch = angle_type'(advance_axis(tp, vp, ep, 2 * k, instant, dt, pitch_vel));
      r.in_range = (ey < sdat_pkg::AIM_TOL && ey > -sdat_pkg::AIM_TOL &&
                    ep < sdat_pkg::AIM_TOL && ep > -sdat_pkg::AIM_TOL);
      pending_q.push_back(r);
      last_pred = r;
   endfunction

   function void report(string what, longint want, longint got);
      errors++;
      if (errors <= 40)
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
   endfunction

   function void check_result(aim_result_type got);
      aim_result_type want;
      if (pending_q.size() == 0) begin
         errors++;
         if (errors <= 40)
            $display("%0t: unexpected beat, expected none, got yaw %0d pitch %0d range %0d",
                     $time, got.yaw, got.pitch, got.in_range);
         return;
      end
      want = pending_q.pop_front();
      if (got.yaw != want.yaw) report("new_yaw", want.yaw, got.yaw);
      if (got.pitch != want.pitch) report("new_pitch", want.pitch, got.pitch);
      if (got.in_range != want.in_range) report("in_aim_range", want.in_range, got.in_range);
   endfunction
endclass

module spring_damper_aim_tracker_core_tb;
   import sdat_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 9;
   localparam int PHASE_BEATS = 92;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [ANGLE_W-1:0]    req_target_yaw = '0;
   logic [ANGLE_W-1:0]    req_target_pitch = '0;
   logic [ANGLE_W-1:0]    req_view_yaw = '0;
   logic [ANGLE_W-1:0]    req_view_pitch = '0;
   logic [DT_W-1:0]       req_time_step = '0;
   logic                  req_is_moving = 1'b0;
   logic                  req_alerted_or_fighting = 1'b0;
   logic                  req_under_attack = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [ANGLE_W-1:0]    rsp_new_yaw;
   logic [ANGLE_W-1:0]    rsp_new_pitch;
   logic                  rsp_in_aim_range;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   aim_scoreboard sb = new();
   int            send_idle_pct = 20;
   int            recv_idle_pct = 79;
   int            hold_left = 0;
   int            cycle_count = 0;
   angle_type     goal_yaw = '0;
   angle_type     goal_pitch = '0;

   int unsigned cfg_min [PHASES] = '{0, 5, 0, 1, 2, 4, 3, 5, 0};
   int unsigned cfg_max [PHASES] = '{0, 5, 5, 3, 4, 5, 1, 0, 2};
   bit          cfg_easy[PHASES] = '{0, 1, 0, 1, 0, 0, 0, 0, 1};

   spring_damper_aim_tracker_core dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_target_yaw          (req_target_yaw),
      .req_target_pitch        (req_target_pitch),
      .req_view_yaw            (req_view_yaw),
      .req_view_pitch          (req_view_pitch),
      .req_time_step           (req_time_step),
      .req_is_moving           (req_is_moving),
      .req_alerted_or_fighting (req_alerted_or_fighting),
      .req_under_attack        (req_under_attack),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_new_yaw             (rsp_new_yaw),
      .rsp_new_pitch           (rsp_new_pitch),
      .rsp_in_aim_range        (rsp_in_aim_range),
      .csr_psel                (csr_psel),
      .csr_penable             (csr_penable),
      .csr_pwrite              (csr_pwrite),
      .csr_paddr               (csr_paddr),
      .csr_pwdata              (csr_pwdata),
      .csr_prdata              (csr_prdata),
      .csr_pready              (csr_pready)
   );

   initial begin : clock_gen
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : receiver
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result({rsp_new_yaw, rsp_new_pitch, rsp_in_aim_range});
   end

   function automatic aim_item_type make_beat(int ty, int tp, int vy, int vp, int dt,
                                              bit mv, bit al, bit at);
      aim_item_type it;
      it.target_yaw   = angle_type'(ty);
      it.target_pitch = angle_type'(tp);
      it.view_yaw     = angle_type'(vy);
      it.view_pitch   = angle_type'(vp);
      it.time_step    = step_type'(dt);
      it.moving       = mv;
      it.alerted      = al;
      it.attacked     = at;
      return it;
   endfunction

   function automatic angle_type move_goal(angle_type goal);
      if ($urandom_range(11) == 0) return angle_type'($urandom_range(23039));
      if ($urandom_range(7) == 0)
         return angle_type'(sb.wrap_turn(longint'(goal) + int'($urandom_range(400)) - 200));
      return goal;
   endfunction

   // Mostly closed-loop tracking from the last predicted view, the rest raw noise.
   function automatic aim_item_type next_random_beat();
      aim_item_type it;
      if ($urandom_range(99) < 25) begin
         it.target_yaw   = angle_type'($urandom);
         it.target_pitch = angle_type'($urandom);
         it.view_yaw     = angle_type'($urandom);
         it.view_pitch   = angle_type'($urandom);
         it.time_step    = step_type'($urandom);
      end else begin
         goal_yaw        = move_goal(goal_yaw);
         goal_pitch      = move_goal(goal_pitch);
         it.target_yaw   = goal_yaw;
         it.target_pitch = goal_pitch;
         it.view_yaw     = sb.last_pred.yaw;
         it.view_pitch   = sb.last_pred.pitch;
         if ($urandom_range(9) == 0) it.time_step = step_type'($urandom);
         else it.time_step = step_type'($urandom_range(4000, 300));
      end
      it.moving   = $urandom_range(1);
      it.alerted  = $urandom_range(1);
      it.attacked = $urandom_range(1);
      return it;
   endfunction

   task automatic send_beat(input aim_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_target_yaw          <= it.target_yaw;
      req_target_pitch        <= it.target_pitch;
      req_view_yaw            <= it.view_yaw;
      req_view_pitch          <= it.view_pitch;
      req_time_step           <= it.time_step;
      req_is_moving           <= it.moving;
      req_alerted_or_fighting <= it.alerted;
      req_under_attack        <= it.attacked;
      req_valid               <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_input(it);
      @(negedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input int unsigned value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * int'(idx));
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic apply_config(input int unsigned lo, input int unsigned hi, input bit easy);
      wait_idle();
      write_reg(REG_MIN_LEVEL, lo);
      write_reg(REG_MAX_LEVEL, hi);
      write_reg(REG_EASY, easy);
   endtask

   task automatic hold_receiver(input int cycles);
      req_valid <= 1'b0;
      @(posedge clock);
      hold_left = cycles;
      @(negedge clock);
   endtask

   initial begin : stimulus
      int p, n;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed beats under reset config
      send_beat(make_beat(0, 0, 0, 0, 0, 0, 0, 0));
      send_beat(make_beat(23039, 0, 0, 23039, 1092, 0, 0, 0));
      send_beat(make_beat(32767, 32767, 32767, 23040, 65535, 1, 1, 1));
      send_beat(make_beat(11520, 0, 0, 11520, 65535, 1, 1, 1));
      send_beat(make_beat(31, 32, 0, 0, 2000, 1, 0, 0));
      send_beat(make_beat(23009, 23008, 0, 0, 2000, 0, 1, 0));
      send_beat(make_beat(191, 22849, 0, 0, 1092, 0, 0, 1));
      send_beat(make_beat(192, 22848, 0, 0, 1092, 0, 0, 0));
      send_beat(make_beat(100, 22900, 23030, 50, 40000, 1, 0, 0));
      send_beat(make_beat(16384, 5461, 10922, 21845, 1, 0, 1, 1));
      send_beat(make_beat(24000, 30000, 23100, 100, 32768, 1, 1, 0));
      send_beat(make_beat(6000, 17000, 0, 0, 65535, 0, 0, 0));
      for (n = 0; n < 8; n++)
         send_beat(make_beat(5000, 18000, sb.last_pred.yaw, sb.last_pred.pitch, 1092,
                             n[0], n[1], n[2]));
      req_valid <= 1'b0;

      for (p = 0; p < PHASES; p++) begin
         apply_config(cfg_min[p], cfg_max[p], cfg_easy[p]);
         if (p < 3) begin
            send_idle_pct = 20;
            recv_idle_pct = 79;
         end else if (p < 6) begin
            send_idle_pct = 79;
            recv_idle_pct = 20;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (n = 0; n < PHASE_BEATS; n++) begin
            if (p == PHASES - 1 && n == 20) hold_receiver(300);
            send_beat(next_random_beat());
         end
         req_valid <= 1'b0;
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/sdat_pkg.sv
rtl/sdat_lane.sv
rtl/spring_damper_aim_tracker_core.sv
sim/spring_damper_aim_tracker_core_tb.sv
